// ===== hw/rtl/address_range_free_map_core_macros.svh =====
// ----------------------------------------------------------------------------
// address range free map assertion macros
// shorthand for the concurrent checks bound to the allocator core
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_FREE_MAP_CORE_MACROS_SVH
`define ADDRESS_RANGE_FREE_MAP_CORE_MACROS_SVH

// check that is masked while reset is asserted
`define ARFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// check that also applies across reset
`define ARFM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/arfm_pkg.sv =====
// ----------------------------------------------------------------------------
// arfm_pkg
// shared widths, codes and types of the address range free map
// ----------------------------------------------------------------------------
`default_nettype none

package arfm_pkg;

  // default sizing
  localparam int MAX_FREE_RANGES_DEF = 16;
  localparam int ADDRESS_BITS_DEF    = 16;

  // port field widths
  localparam int OP_W        = 1;
  localparam int ADDR_IN_W   = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  // request operations
  localparam logic [OP_W-1:0] OP_ALLOCATE = 1'b0;
  localparam logic [OP_W-1:0] OP_RESERVE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK              = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CONFLICT        = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_START_AFTER_END = 2'd3;

  // outcome of comparing one stored range against the request
  typedef struct packed {
    logic hit;    // range is cut by the request
    logic left;   // a piece survives below the request
    logic right;  // a piece survives above the request
  } cut_t;

endpackage

`default_nettype wire

// ===== hw/rtl/arfm_req_if.sv =====
// ----------------------------------------------------------------------------
// arfm_req_if
// request channel of the address range free map: operation and range
// ----------------------------------------------------------------------------
`default_nettype none

interface arfm_req_if;
  logic                                valid;
  logic                                ready;
  logic [arfm_pkg::OP_W-1:0]           operation;
  logic [arfm_pkg::ADDR_IN_W-1:0]      start_address;
  logic [arfm_pkg::ADDR_IN_W-1:0]      end_address;

  modport source (output valid, operation, start_address, end_address, input ready);
  modport sink   (input valid, operation, start_address, end_address, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/arfm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// arfm_rsp_if
// result channel of the address range free map: status and range count
// ----------------------------------------------------------------------------
`default_nettype none

interface arfm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [arfm_pkg::STATUS_W-1:0]       status;
  logic [arfm_pkg::COUNT_OUT_W-1:0]    ranges_in_use;

  modport source (output valid, status, ranges_in_use, input ready);
  modport sink   (input valid, status, ranges_in_use, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/arfm_table.sv =====
// ----------------------------------------------------------------------------
// arfm_table
// two-bank range storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module arfm_table #(
  parameter int ADDR_W = 5,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/arfm_cut.sv =====
// ----------------------------------------------------------------------------
// arfm_cut
// shared compare unit: tests one stored range against the request range
// ----------------------------------------------------------------------------
`default_nettype none

module arfm_cut #(
  parameter int ADDRESS_BITS = arfm_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic [arfm_pkg::OP_W-1:0] op,
  input  wire logic [ADDRESS_BITS-1:0]   start_address,
  input  wire logic [ADDRESS_BITS-1:0]   end_address,
  input  wire logic [ADDRESS_BITS-1:0]   first,
  input  wire logic [ADDRESS_BITS-1:0]   last,
  output arfm_pkg::cut_t                 flags,
  output logic      [ADDRESS_BITS-1:0]   left_last,
  output logic      [ADDRESS_BITS-1:0]   right_first
);

  logic overlap;
  logic contains;

  always_comb begin
    overlap     = (last >= start_address) && (first <= end_address);
    contains    = (first <= start_address) && (end_address <= last);
    // reserve cuts anything it touches, allocate only its enclosing range
    flags.hit   = (op == arfm_pkg::OP_RESERVE) ? overlap : contains;
    flags.left  = first < start_address;
    flags.right = last > end_address;
    left_last   = start_address - ADDRESS_BITS'(1);
    right_first = end_address + ADDRESS_BITS'(1);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/address_range_free_map_core.sv =====
// ----------------------------------------------------------------------------
// address_range_free_map_core
// sorted table of disjoint free address ranges with allocate and reserve
// ----------------------------------------------------------------------------
// The core keeps up to MAX_FREE_RANGES free ranges in ascending order. An
// allocate request claims exactly [start, end] and must sit inside one free
// range, otherwise status is conflict. A reserve request removes [start, end]
// from the free set and ignores addresses that are already taken. Either
// request may split a range; if the result would need more than
// MAX_FREE_RANGES entries the status is table_full. A start above the end
// reports start_after_end. In every failing case the table is left as it was,
// and ranges_in_use always reports the count held after the request.
// The table lives in a two-bank memory: each request streams the current bank
// through one shared compare unit, one stored range at a time, and writes the
// surviving pieces into the other bank, which becomes current on success.
// Each stored range passes through a read state and a compare-and-write
// state, plus a third state when it is split in two, since the memory has a
// single write port. A request thus passes through the accepting state, the
// read and compare states of each range held when it is accepted, one more
// state per split and a closing state that loads the result into the output
// register. start_after_end or an empty table goes straight from acceptance
// to the closing state. The closing state waits as long as an older result
// still sits in the output register; no new request is taken meanwhile. The
// output register lets the next request be accepted while an earlier result
// waits to be taken. After reset the core writes the initial full-space
// range in its init state before it raises ready.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_free_map_core #(
  parameter int MAX_FREE_RANGES = arfm_pkg::MAX_FREE_RANGES_DEF,
  parameter int ADDRESS_BITS    = arfm_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  arfm_req_if.sink   req,
  arfm_rsp_if.source rsp
);

  localparam int IW     = $clog2(MAX_FREE_RANGES);      // entry index
  localparam int CW     = $clog2(MAX_FREE_RANGES + 1);  // range count
  localparam int NW     = $clog2(MAX_FREE_RANGES + 2);  // fill, one past full
  localparam int MW     = IW + 1;                       // bank plus index
  localparam int EW     = 2 * ADDRESS_BITS;             // first and last
  localparam int OUT_CW = arfm_pkg::COUNT_OUT_W;

  // sequencer states
  localparam logic [2:0] ST_INIT  = 3'd0;  // write initial full-space range
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a request
  localparam logic [2:0] ST_READ  = 3'd2;  // read next stored range
  localparam logic [2:0] ST_EVAL  = 3'd3;  // compare, write first piece
  localparam logic [2:0] ST_RIGHT = 3'd4;  // write upper piece of a split
  localparam logic [2:0] ST_DONE  = 3'd5;  // commit or drop, post result

  logic [2:0]                    state, state_next;
  logic                          bank, bank_next;       // current table bank
  logic [CW-1:0]                 count, count_next;     // ranges held
  logic [CW-1:0]                 idx, idx_next;         // range being read
  logic [NW-1:0]                 fill, fill_next;       // ranges produced
  logic                          found, found_next;     // some range was cut
  logic [arfm_pkg::OP_W-1:0]     op, op_next;
  logic [ADDRESS_BITS-1:0]       lo, lo_next;
  logic [ADDRESS_BITS-1:0]       hi, hi_next;
  logic                          order_err, order_err_next;
  logic                          out_valid, out_valid_next;
  logic [arfm_pkg::STATUS_W-1:0] out_status, out_status_next;
  logic [OUT_CW-1:0]             out_ranges, out_ranges_next;

  // table port
  logic                          wr_en;
  logic [MW-1:0]                 wr_addr;
  logic [EW-1:0]                 wr_data;
  logic                          rd_en;
  logic [MW-1:0]                 rd_addr;
  logic [EW-1:0]                 rd_data;

  // compare unit
  logic [ADDRESS_BITS-1:0]       entry_first;
  logic [ADDRESS_BITS-1:0]       entry_last;
  arfm_pkg::cut_t                cut;
  logic [ADDRESS_BITS-1:0]       left_last;
  logic [ADDRESS_BITS-1:0]       right_first;

  // helpers
  logic [ADDRESS_BITS-1:0]       req_lo;
  logic [ADDRESS_BITS-1:0]       req_hi;
  logic [NW-1:0]                 fill_inc;
  logic                          fill_room;
  logic [CW-1:0]                 idx_inc;
  logic                          idx_last;

  assign entry_first = rd_data[EW-1:ADDRESS_BITS];
  assign entry_last  = rd_data[ADDRESS_BITS-1:0];

  arfm_table #(
    .ADDR_W (MW),
    .DATA_W (EW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  arfm_cut #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_cut (
    .op            (op),
    .start_address (lo),
    .end_address   (hi),
    .first         (entry_first),
    .last          (entry_last),
    .flags         (cut),
    .left_last     (left_last),
    .right_first   (right_first)
  );

  always_comb begin
    state_next      = state;
    bank_next       = bank;
    count_next      = count;
    idx_next        = idx;
    fill_next       = fill;
    found_next      = found;
    op_next         = op;
    lo_next         = lo;
    hi_next         = hi;
    order_err_next  = order_err;
    // output register drains whenever the sink takes it
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_ranges_next = out_ranges;

    // addresses are cut or widened to the table width
    req_lo    = ADDRESS_BITS'(req.start_address);
    req_hi    = ADDRESS_BITS'(req.end_address);

    // fill saturates one past full; writes stop once the bank is full
    fill_inc  = (fill == NW'(MAX_FREE_RANGES + 1)) ? fill : fill + NW'(1);
    fill_room = fill < NW'(MAX_FREE_RANGES);
    idx_inc   = idx + CW'(1);
    idx_last  = idx_inc == count;

    wr_en   = 1'b0;
    wr_addr = {~bank, fill[IW-1:0]};
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = {bank, idx[IW-1:0]};

    unique case (state)
      ST_INIT: begin
        // bank 0 entry 0 holds the whole address space
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = {{ADDRESS_BITS{1'b0}}, {ADDRESS_BITS{1'b1}}};
        state_next = ST_IDLE;
      end

      ST_IDLE: begin
        if (req.valid) begin
          op_next        = req.operation;
          lo_next        = req_lo;
          hi_next        = req_hi;
          idx_next       = '0;
          fill_next      = '0;
          found_next     = 1'b0;
          order_err_next = req_lo > req_hi;
          if ((req_lo > req_hi) || (count == '0)) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end
      end

      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_EVAL;
      end

      ST_EVAL: begin
        if (!cut.hit) begin
          // untouched range is copied as it stands
          wr_en     = fill_room;
          wr_data   = rd_data;
          fill_next = fill_inc;
        end else begin
          found_next = 1'b1;
          if (cut.left || cut.right) begin
            wr_en     = fill_room;
            wr_data   = cut.left ? {entry_first, left_last} : {right_first, entry_last};
            fill_next = fill_inc;
          end
        end
        if (cut.hit && cut.left && cut.right) begin
          state_next = ST_RIGHT;
        end else begin
          idx_next   = idx_inc;
          state_next = idx_last ? ST_DONE : ST_READ;
        end
      end

      ST_RIGHT: begin
        wr_en      = fill_room;
        wr_data    = {right_first, entry_last};
        fill_next  = fill_inc;
        idx_next   = idx_inc;
        state_next = idx_last ? ST_DONE : ST_READ;
      end

      ST_DONE: begin
        // wait while an older result still sits in the output register
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_ranges_next = OUT_CW'(count);
          state_next      = ST_IDLE;
          if (order_err) begin
            out_status_next = arfm_pkg::STATUS_START_AFTER_END;
          end else if ((op == arfm_pkg::OP_ALLOCATE) && !found) begin
            out_status_next = arfm_pkg::STATUS_CONFLICT;
          end else if (fill > NW'(MAX_FREE_RANGES)) begin
            out_status_next = arfm_pkg::STATUS_TABLE_FULL;
          end else begin
            // new bank becomes the table
            out_status_next = arfm_pkg::STATUS_OK;
            count_next      = CW'(fill);
            bank_next       = ~bank;
            out_ranges_next = OUT_CW'(fill);
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      bank      <= 1'b0;
      count     <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bank      <= bank_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // request working copy and result payload
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    fill       <= fill_next;
    found      <= found_next;
    op         <= op_next;
    lo         <= lo_next;
    hi         <= hi_next;
    order_err  <= order_err_next;
    out_status <= out_status_next;
    out_ranges <= out_ranges_next;
  end

  assign req.ready         = state == ST_IDLE;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.ranges_in_use = out_ranges;

endmodule

`default_nettype wire

// ===== hw/rtl/arfm_checker.sv =====
// ----------------------------------------------------------------------------
// arfm_checker
// port-level checks of the address range free map core, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "address_range_free_map_core_macros.svh"

module arfm_checker #(
  parameter int MAX_FREE_RANGES = arfm_pkg::MAX_FREE_RANGES_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             req_valid,
  input wire logic                             req_ready,
  input wire logic                             rsp_valid,
  input wire logic                             rsp_ready,
  input wire logic [arfm_pkg::STATUS_W-1:0]    status,
  input wire logic [arfm_pkg::COUNT_OUT_W-1:0] ranges_in_use
);

  // reset leaves no result pending and runs the init write first
  `ARFM_ASSERT_RST(a_reset_quiet, rst |=> !rsp_valid && !req_ready, "core not quiet after reset")

  // one request at a time: ready drops right after an acceptance
  `ARFM_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "request taken while busy")

  // a stalled result holds its payload
  `ARFM_ASSERT(a_result_holds, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(ranges_in_use), "stalled result changed")

  // the count never exceeds the table size
  `ARFM_ASSERT(a_count_bound, rsp_valid |-> ranges_in_use <= MAX_FREE_RANGES, "range count above table size")

endmodule

bind address_range_free_map_core arfm_checker #(
  .MAX_FREE_RANGES (MAX_FREE_RANGES)
) u_arfm_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .ranges_in_use (rsp.ranges_in_use)
);

`default_nettype wire

// ===== dv/address_range_free_map_core_checker.sv =====
// ----------------------------------------------------------------------------
// address_range_free_map_core_checker
// watches both channels, predicts each result and compares it on arrival
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_free_map_core_checker (
  input  wire logic clk,
  input  wire logic rst,
  arfm_req_if       req,
  arfm_rsp_if       rsp,
  output int        failures,
  output int        pending,
  output logic [arfm_pkg::ADDRESS_BITS_DEF-1:0] map_first [arfm_pkg::MAX_FREE_RANGES_DEF],
  output logic [arfm_pkg::ADDRESS_BITS_DEF-1:0] map_last  [arfm_pkg::MAX_FREE_RANGES_DEF],
  output int        map_count,
  output int        result_tally [4],
  output int        peak_ranges
);
  import arfm_pkg::*;

  localparam int TABLE_DEPTH = MAX_FREE_RANGES_DEF;
  localparam int AW          = ADDRESS_BITS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] ranges;
  } outcome_t;

  // predicted free table, ascending, entries below free_count only
  logic [AW-1:0] free_first [TABLE_DEPTH];
  logic [AW-1:0] free_last  [TABLE_DEPTH];
  int            free_count;
  outcome_t      pending_outcomes [$];
  int            tally [4];
  int            peak;

  // allocate: the range must sit inside a single free range
  function automatic logic [STATUS_W-1:0] claim_exact(logic [AW-1:0] lo, logic [AW-1:0] hi);
    int idx;
    int k;
    idx = 0;
    while (idx < free_count && lo > free_last[idx]) idx++;
    if (idx >= free_count || lo < free_first[idx] || hi > free_last[idx])
      return STATUS_CONFLICT;
    if (lo == free_first[idx] && hi == free_last[idx]) begin
      for (k = idx; k + 1 < free_count; k++) begin
        free_first[k] = free_first[k+1];
        free_last[k]  = free_last[k+1];
      end
      free_count--;
    end else if (lo == free_first[idx]) begin
      free_first[idx] = hi + 1'b1;
    end else if (hi == free_last[idx]) begin
      free_last[idx] = lo - 1'b1;
    end else begin
      if (free_count >= TABLE_DEPTH) return STATUS_TABLE_FULL;
      for (k = free_count; k > idx + 1; k--) begin
        free_first[k] = free_first[k-1];
        free_last[k]  = free_last[k-1];
      end
      free_first[idx+1] = hi + 1'b1;
      free_last[idx+1]  = free_last[idx];
      free_last[idx]    = lo - 1'b1;
      free_count++;
    end
    return STATUS_OK;
  endfunction

  // reserve: plain subtraction of [lo, hi] from the free set
  function automatic logic [STATUS_W-1:0] carve_out(logic [AW-1:0] lo, logic [AW-1:0] hi);
    logic [AW-1:0] kept_first [TABLE_DEPTH+1];
    logic [AW-1:0] kept_last  [TABLE_DEPTH+1];
    int n;
    int idx;
    n = 0;
    for (idx = 0; idx < free_count; idx++) begin
      if (free_last[idx] < lo || free_first[idx] > hi) begin
        kept_first[n] = free_first[idx];
        kept_last[n]  = free_last[idx];
        n++;
      end else begin
        if (free_first[idx] < lo) begin
          kept_first[n] = free_first[idx];
          kept_last[n]  = lo - 1'b1;
          n++;
        end
        if (free_last[idx] > hi) begin
          kept_first[n] = hi + 1'b1;
          kept_last[n]  = free_last[idx];
          n++;
        end
      end
    end
    if (n > TABLE_DEPTH) return STATUS_TABLE_FULL;
    for (idx = 0; idx < n; idx++) begin
      free_first[idx] = kept_first[idx];
      free_last[idx]  = kept_last[idx];
    end
    free_count = n;
    return STATUS_OK;
  endfunction

  function automatic outcome_t predict(logic [OP_W-1:0] op, logic [AW-1:0] lo,
                                       logic [AW-1:0] hi);
    outcome_t o;
    if (lo > hi)
      o.status = STATUS_START_AFTER_END;
    else if (op == OP_ALLOCATE)
      o.status = claim_exact(lo, hi);
    else
      o.status = carve_out(lo, hi);
    o.ranges = COUNT_OUT_W'(free_count);
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      free_first[0] = '0;
      free_last[0]  = '1;
      free_count    = 1;
      peak          = 1;
      failures      = 0;
      tally         = '{default: 0};
      pending_outcomes.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result with no request waiting: status %0d, ranges_in_use %0d",
                 rsp.status, rsp.ranges_in_use);
          failures++;
        end else begin
          want = pending_outcomes.pop_front();
          tally[want.status]++;
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
            failures++;
          end
          if (rsp.ranges_in_use !== want.ranges) begin
            $error("ranges_in_use mismatch: expected %0d, actual %0d",
                   want.ranges, rsp.ranges_in_use);
            failures++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_outcomes.push_back(predict(req.operation, req.start_address[AW-1:0],
                                           req.end_address[AW-1:0]));
        if (free_count > peak) peak = free_count;
      end
    end
    pending      <= pending_outcomes.size();
    map_first    <= free_first;
    map_last     <= free_last;
    map_count    <= free_count;
    result_tally <= tally;
    peak_ranges  <= peak;
  end

endmodule

`default_nettype wire

// ===== dv/address_range_free_map_core_test.sv =====
// ----------------------------------------------------------------------------
// address_range_free_map_core_test
// top of the free map testbench: clock, reset, stimulus and verdict
// ----------------------------------------------------------------------------
// A directed opening walks the table through trims, splits, a full table and
// whole-range removal; a random body then aims most requests at the edges
// and insides of the ranges currently free, mixed with stray and malformed
// requests. Free space only ever shrinks until reset, so emptying the table
// is left to a short closing sequence. A separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_free_map_core_test;
  import arfm_pkg::*;

  localparam int TABLE_DEPTH     = MAX_FREE_RANGES_DEF;
  localparam int AW              = ADDRESS_BITS_DEF;
  localparam int ADDR_MAX        = (1 << AW) - 1;
  localparam int RANDOM_REQUESTS = 570;
  // request window in which neither side idles
  localparam int QUIET_FROM      = 150;
  localparam int QUIET_TO        = 260;
  // request index at which the result side goes deaf for a while
  localparam int HOLD_AT         = 360;
  localparam int HOLD_CYCLES     = 400;
  // drain allowance sized from the worst-case request, with every range split
  localparam int DRAIN_CYCLES    = 4 * (2 + 3 * TABLE_DEPTH);
  localparam int CYCLE_LIMIT     = 400000;

  logic clk = 1'b0;
  logic rst;
  logic steady;
  logic hold_off_req;

  arfm_req_if req ();
  arfm_rsp_if rsp ();

  // predicted table, mirrored out of the checker; used only to aim requests
  logic [AW-1:0] map_first [TABLE_DEPTH];
  logic [AW-1:0] map_last  [TABLE_DEPTH];
  int            map_count;
  int            fault_total;
  int            awaiting;
  int            result_tally [4];
  int            peak_ranges;
  int            alloc_sent;
  int            reserve_sent;

  address_range_free_map_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  address_range_free_map_core_checker results_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .failures     (fault_total),
    .pending      (awaiting),
    .map_first    (map_first),
    .map_last     (map_last),
    .map_count    (map_count),
    .result_tally (result_tally),
    .peak_ranges  (peak_ranges)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the handshake hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side: random back-pressure, one long hold-off while requests pile up
  initial begin : result_taker
    int n;
    bit hold_done;
    hold_done = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        rsp.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_done = 1'b1;
      end
      rsp.ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  // one request: random idle gap unless in the quiet window, then hold
  // valid until the block takes it
  task automatic offer(input logic [OP_W-1:0] op, input int lo, input int hi);
    while (!steady && $urandom_range(99) < 34) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.operation     <= op;
    req.start_address <= ADDR_IN_W'(lo);
    req.end_address   <= ADDR_IN_W'(hi);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (op == OP_ALLOCATE) alloc_sent++;
    else reserve_sent++;
  endtask

  initial begin : stimulus
    int r;
    int k;
    int pick;
    int idx;
    int f_i;
    int l_i;
    int span;
    int len;
    int anchor;
    int lo_i;
    int hi_i;
    int a;
    int b;
    logic [OP_W-1:0] op;

    alloc_sent   = 0;
    reserve_sent = 0;
    rst               <= 1'b1;
    steady            <= 1'b0;
    hold_off_req      <= 1'b0;
    req.valid         <= 1'b0;
    req.operation     <= OP_ALLOCATE;
    req.start_address <= '0;
    req.end_address   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed opening ---
    // start above end, for both operations and the extreme addresses
    offer(OP_ALLOCATE, 5, 4);
    offer(OP_RESERVE, ADDR_MAX, 0);
    // trim the bottom address, then the top one
    offer(OP_RESERVE, 0, 0);
    offer(OP_ALLOCATE, ADDR_MAX, ADDR_MAX);
    // below the first free range, a split in the middle, then beyond the last one
    offer(OP_ALLOCATE, 0, 0);
    offer(OP_ALLOCATE, 'h8000, 'h8000);
    offer(OP_ALLOCATE, ADDR_MAX, ADDR_MAX);
    // straddles the gap between two free ranges
    offer(OP_ALLOCATE, 'h7000, 'h8fff);
    // reserve across the gap trims both neighbors
    offer(OP_RESERVE, 'h7f00, 'h80ff);
    // reserve of space already taken touches nothing
    offer(OP_RESERVE, 'h8000, 'h80ff);
    offer(OP_ALLOCATE, 1, 'h10);
    // single-address splits fill the table to the brim
    for (k = 1; k < 8; k++) begin
      offer(OP_ALLOCATE, k << 12, k << 12);
      offer(OP_ALLOCATE, 'h8000 + (k << 12), 'h8000 + (k << 12));
    end
    // any further split must be refused, by either operation
    offer(OP_ALLOCATE, 'h1800, 'h1800);
    offer(OP_RESERVE, 'h2800, 'h2800);
    // reserve over a used address trims the ranges on both sides
    offer(OP_RESERVE, 'h0f00, 'h1100);
    // reserve swallowing several whole ranges
    offer(OP_RESERVE, 'h2000, 'h5fff);
    // exact fit removes a range
    offer(OP_ALLOCATE, 'h6001, 'h6fff);
    offer(OP_ALLOCATE, 0, ADDR_MAX);
    offer(OP_RESERVE, ADDR_MAX, ADDR_MAX);

    // --- random body ---
    for (r = 0; r < RANDOM_REQUESTS; r++) begin
      steady <= (r >= QUIET_FROM && r < QUIET_TO);
      if (r == HOLD_AT) hold_off_req <= 1'b1;
      pick = $urandom_range(99);
      op   = OP_ALLOCATE;
      // pick a free range to aim at
      if (map_count > 0) begin
        idx = $urandom_range(map_count - 1);
        f_i = map_first[idx];
        l_i = map_last[idx];
      end else begin
        f_i = $urandom_range(ADDR_MAX);
        l_i = f_i;
      end
      span = l_i - f_i;
      if (pick < 40) begin
        // allocate at the bottom, the top, the inside or the whole range
        len = $urandom_range(31);
        if (len > span) len = span;
        case ($urandom_range(3))
          0: begin
            lo_i = f_i;
            hi_i = f_i + len;
          end
          1: begin
            lo_i = l_i - len;
            hi_i = l_i;
          end
          2: begin
            lo_i = f_i + $urandom_range(span);
            hi_i = (lo_i + len > l_i) ? l_i : lo_i + len;
          end
          default: begin
            // whole-range removal only where it costs little space
            lo_i = f_i;
            hi_i = (span < 256 || map_count > 8) ? l_i : f_i + len;
          end
        endcase
      end else if (pick < 65 || (pick >= 80 && pick < 88)) begin
        // reserve around a range edge, or anywhere; now and then a wide one
        op     = OP_RESERVE;
        len    = ($urandom_range(15) == 0) ? $urandom_range(4095) : $urandom_range(63);
        anchor = (pick >= 80) ? $urandom_range(ADDR_MAX) :
                 ($urandom_range(1) ? f_i : l_i);
        lo_i   = anchor - $urandom_range(len);
        if (lo_i < 0) lo_i = 0;
        hi_i = lo_i + len;
        if (hi_i > ADDR_MAX) hi_i = ADDR_MAX;
      end else if (pick < 80) begin
        // stray allocate, mostly a conflict
        lo_i = $urandom_range(ADDR_MAX);
        hi_i = lo_i + $urandom_range(15);
        if (hi_i > ADDR_MAX) hi_i = ADDR_MAX;
      end else begin
        // malformed: full random bits with the larger address first
        op = $urandom_range(1) ? OP_RESERVE : OP_ALLOCATE;
        a  = $urandom_range(ADDR_MAX);
        b  = $urandom_range(ADDR_MAX);
        lo_i = (a > b) ? a : b;
        hi_i = (a > b) ? b : a;
      end
      offer(op, lo_i, hi_i);
    end

    // --- closing: empty the table, then hit it while empty ---
    offer(OP_RESERVE, 0, ADDR_MAX);
    offer(OP_ALLOCATE, 'h1234, 'h1234);
    offer(OP_RESERVE, 0, 0);
    offer(OP_ALLOCATE, 0, ADDR_MAX);
    offer(OP_ALLOCATE, ADDR_MAX, 0);
    req.valid <= 1'b0;

    // let the last expectation land in the checker, then drain
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d allocate and %0d reserve requests, table peaked at %0d ranges",
             alloc_sent, reserve_sent, peak_ranges);
    $display("results: %0d ok, %0d conflict, %0d table_full, %0d start_after_end",
             result_tally[STATUS_OK], result_tally[STATUS_CONFLICT],
             result_tally[STATUS_TABLE_FULL], result_tally[STATUS_START_AFTER_END]);
    if (fault_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/arfm_pkg.sv
hw/rtl/arfm_req_if.sv
hw/rtl/arfm_rsp_if.sv
hw/rtl/arfm_table.sv
hw/rtl/arfm_cut.sv
hw/rtl/address_range_free_map_core.sv
hw/rtl/arfm_checker.sv
dv/address_range_free_map_core_checker.sv
dv/address_range_free_map_core_test.sv
